/* rtl/core/swc_pkg.sv */
package swc_pkg;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    LX_BETWEEN = 3'd0,
    LX_NORMAL  = 3'd1,
    LX_DQUOTE  = 3'd2,
    LX_SQUOTE  = 3'd3,
    LX_ESCAPE  = 3'd4,
    LX_QESCAPE = 3'd5
  } lex_state_t;

  localparam logic       OP_CHAR = 1'b0;
  localparam logic       OP_EOL  = 1'b1;

  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [20:0] CH_BSLASH = 21'h5C;
  localparam logic [20:0] CH_DQ     = 21'h22;
  localparam logic [20:0] CH_SQ     = 21'h27;

  localparam logic [11:0] WC_MAX = 12'hFFF;
  localparam logic [12:0] VL_MAX = 13'h1FFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [20:0] value_char;
    logic [11:0] word_index;
    logic [12:0] cursor_prefix_len;
    logic        cursor_in_word;
    logic        last;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

endpackage

/* rtl/core/swc_front.sv */
module swc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             op,
  input  logic [20:0]      ch,
  input  logic             at_cursor,
  input  logic             q_full,
  output swc_pkg::slot_t   push
);

  swc_pkg::lex_state_t lex, lex_next;
  logic [11:0] word_count, word_count_next;
  logic [12:0] value_length, value_length_next;
  logic        cursor_found, cursor_found_next;
  logic [11:0] cursor_word, cursor_word_next;
  logic [12:0] cursor_prefix, cursor_prefix_next;
  logic        cursor_before_first, cursor_before_first_next;
  logic        cursor_inside, cursor_inside_next;

  logic accept;
  logic blank;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign blank    = ch inside {21'd32, [21'd9:21'd13]};

  always_ff @(posedge clk) begin
    if (rst) begin
      lex                 <= swc_pkg::LX_BETWEEN;
      word_count          <= '0;
      value_length        <= '0;
      cursor_found        <= 1'b0;
      cursor_word         <= '0;
      cursor_prefix       <= '0;
      cursor_before_first <= 1'b0;
      cursor_inside       <= 1'b0;
    end else begin
      lex                 <= lex_next;
      word_count          <= word_count_next;
      value_length        <= value_length_next;
      cursor_found        <= cursor_found_next;
      cursor_word         <= cursor_word_next;
      cursor_prefix       <= cursor_prefix_next;
      cursor_before_first <= cursor_before_first_next;
      cursor_inside       <= cursor_inside_next;
    end
  end

  always_comb begin
    logic [11:0]         wc_end;
    swc_pkg::res_t       sum;
    logic                keep;
    swc_pkg::lex_state_t eff;

    lex_next                 = lex;
    word_count_next          = word_count;
    value_length_next        = value_length;
    cursor_found_next        = cursor_found;
    cursor_word_next         = cursor_word;
    cursor_prefix_next       = cursor_prefix;
    cursor_before_first_next = cursor_before_first;
    cursor_inside_next       = cursor_inside;
    push                     = '0;
    wc_end                   = word_count;
    sum                      = '0;
    keep                     = 1'b0;
    eff                      = lex;

    if (accept) begin
      if (op == swc_pkg::OP_EOL) begin
        if (lex != swc_pkg::LX_BETWEEN) begin
          if (at_cursor && !cursor_found) begin
            cursor_found_next  = 1'b1;
            cursor_inside_next = 1'b1;
            cursor_word_next   = word_count;
            cursor_prefix_next = value_length;
          end
          push.entry.two           = 1'b1;
          push.entry.r0.kind       = swc_pkg::KIND_END;
          push.entry.r0.word_index = word_count;
          if (word_count < swc_pkg::WC_MAX) begin
            wc_end = word_count + 12'd1;
          end
        end else if (at_cursor && !cursor_found) begin
          cursor_found_next        = 1'b1;
          cursor_before_first_next = (word_count == 12'd0);
        end
        sum.kind = swc_pkg::KIND_SUMMARY;
        sum.last = 1'b1;
        if (cursor_found_next) begin
          if (cursor_inside_next) begin
            sum.word_index        = cursor_word_next;
            sum.cursor_prefix_len = cursor_prefix_next;
            sum.cursor_in_word    = 1'b1;
          end else if (!cursor_before_first_next) begin
            sum.word_index = wc_end;
          end
        end
        if (push.entry.two) begin
          push.entry.r1 = sum;
        end else begin
          push.entry.r0 = sum;
        end
        push.valid = 1'b1;

        lex_next                 = swc_pkg::LX_BETWEEN;
        word_count_next          = '0;
        value_length_next        = '0;
        cursor_found_next        = 1'b0;
        cursor_word_next         = '0;
        cursor_prefix_next       = '0;
        cursor_before_first_next = 1'b0;
        cursor_inside_next       = 1'b0;
      end else if (lex == swc_pkg::LX_BETWEEN && blank) begin
        if (at_cursor && !cursor_found) begin
          cursor_found_next        = 1'b1;
          cursor_before_first_next = (word_count == 12'd0);
        end
      end else begin
        eff      = (lex == swc_pkg::LX_BETWEEN) ? swc_pkg::LX_NORMAL : lex;
        lex_next = eff;
        if (at_cursor && !cursor_found) begin
          cursor_found_next  = 1'b1;
          cursor_inside_next = 1'b1;
          cursor_word_next   = word_count;
          cursor_prefix_next = value_length;
        end
        case (eff)
          swc_pkg::LX_NORMAL: begin
            if (blank) begin
              push.valid               = 1'b1;
              push.entry.r0.kind       = swc_pkg::KIND_END;
              push.entry.r0.word_index = word_count;
              push.entry.r0.last       = 1'b1;
              lex_next                 = swc_pkg::LX_BETWEEN;
              value_length_next        = '0;
              if (word_count < swc_pkg::WC_MAX) begin
                word_count_next = word_count + 12'd1;
              end
            end else if (ch == swc_pkg::CH_BSLASH) begin
              lex_next = swc_pkg::LX_ESCAPE;
            end else if (ch == swc_pkg::CH_DQ) begin
              lex_next = swc_pkg::LX_DQUOTE;
            end else if (ch == swc_pkg::CH_SQ) begin
              lex_next = swc_pkg::LX_SQUOTE;
            end else begin
              keep = 1'b1;
            end
          end
          swc_pkg::LX_DQUOTE: begin
            if (ch == swc_pkg::CH_DQ) begin
              lex_next = swc_pkg::LX_NORMAL;
            end else if (ch == swc_pkg::CH_BSLASH) begin
              lex_next = swc_pkg::LX_QESCAPE;
            end else begin
              keep = 1'b1;
            end
          end
          swc_pkg::LX_SQUOTE: begin
            if (ch == swc_pkg::CH_SQ) begin
              lex_next = swc_pkg::LX_NORMAL;
            end else begin
              keep = 1'b1;
            end
          end
          swc_pkg::LX_ESCAPE: begin
            lex_next = swc_pkg::LX_NORMAL;
            keep     = 1'b1;
          end
          swc_pkg::LX_QESCAPE: begin
            lex_next = swc_pkg::LX_DQUOTE;
            keep     = 1'b1;
          end
          default: begin
            lex_next = swc_pkg::LX_NORMAL;
            keep     = 1'b1;
          end
        endcase
        if (keep) begin
          push.valid               = 1'b1;
          push.entry.r0.kind       = swc_pkg::KIND_CHAR;
          push.entry.r0.value_char = ch;
          push.entry.r0.word_index = word_count;
          push.entry.r0.last       = 1'b1;
          if (value_length < swc_pkg::VL_MAX) begin
            value_length_next = value_length + 13'd1;
          end
        end
      end
    end
  end

endmodule

/* rtl/core/swc_queue.sv */
module swc_queue #(
  parameter int DEPTH = swc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  swc_pkg::slot_t push,
  input  logic           pop,
  output logic           full,
  output swc_pkg::slot_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  swc_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push.valid && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push.valid) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/core/swc_back.sv */
module swc_back (
  input  logic           clk,
  input  logic           rst,
  input  swc_pkg::slot_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output swc_pkg::res_t  res
);

  logic          out_valid_next;
  logic          phase, phase_next;
  swc_pkg::res_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      phase     <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  always_comb begin
    pop            = 1'b0;
    phase_next     = phase;
    out_valid_next = out_valid;
    res_next       = res;
    if (!out_valid || !out_stall) begin
      if (phase) begin
        res_next       = head.entry.r1;
        out_valid_next = 1'b1;
        pop            = 1'b1;
        phase_next     = 1'b0;
      end else if (head.valid) begin
        res_next       = head.entry.r0;
        out_valid_next = 1'b1;
        if (head.entry.two) begin
          phase_next = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

endmodule

/* rtl/core/shell_word_splitter_with_cursor.sv */
// Shell-style word splitter with cursor tracking.
// Input channel (in_valid, in_stall): one transfer per line character (op = 0)
// or end of line (op = 1), with at_cursor marking the editing cursor position.
// Output channel (out_valid, out_stall): value characters, word ends and one
// cursor summary per line; last marks the final result of each input transfer.
// A new input transfer can be taken every cycle while the queue has room. The
// lexer state updates in the cycle of the transfer, and its first result
// passes through the queue and then the output register. An end of line
// inside an open word yields two results, which leave the output in turn.
// Between lexer and output sits a queue of QUEUE_DEPTH entries, one entry
// per input transfer that has results; in_stall is high exactly while that
// queue is full, so a stalled receiver backs up into the input only after
// the queue has filled. The output register holds its result while stalled.
// Reset returns the lexer to between words, clears all counters and cursor
// marks, and empties the queue; no clearing pass is needed.
module shell_word_splitter_with_cursor #(
  parameter int QUEUE_DEPTH = swc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [20:0] ch,
  input  logic        at_cursor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [20:0] value_char,
  output logic [11:0] word_index,
  output logic [12:0] cursor_prefix_len,
  output logic        cursor_in_word,
  output logic        last
);

  swc_pkg::slot_t push;
  swc_pkg::slot_t head;
  swc_pkg::res_t  res;
  logic           q_full;
  logic           pop;

  swc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .ch        (ch),
    .at_cursor (at_cursor),
    .q_full    (q_full),
    .push      (push)
  );

  swc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  swc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign kind              = res.kind;
  assign value_char        = res.value_char;
  assign word_index        = res.word_index;
  assign cursor_prefix_len = res.cursor_prefix_len;
  assign cursor_in_word    = res.cursor_in_word;
  assign last              = res.last;

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == swc_pkg::KIND_SUMMARY |-> last)
    else $error("cursor summary without last");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && kind == swc_pkg::KIND_SUMMARY)
    else $error("word end at end of line not followed by summary");

  a_char_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != swc_pkg::KIND_CHAR |-> value_char == 21'd0)
    else $error("value character set on a non-character result");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !push.valid)
    else $error("queue written while full");

endmodule
